@@ hw/rtl/aes_pkg.sv @@
package aes_pkg;

    localparam int ROUND_COUNT_DEF = 14;
    localparam int NUM_KEY_REGS    = 4;
    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXP   = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        gmul = p;
    endfunction

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // state as 16 bytes, byte 0 in bits 127:120
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] o [16];
        for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r+4*c] = b[r + 4*((c+r)%4)];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[r+4*c] = last ? t[r+4*c] :
                    (xtime(t[r+4*c]) ^ xtime(t[(r+1)%4+4*c]) ^ t[(r+1)%4+4*c]
                     ^ t[(r+2)%4+4*c] ^ t[(r+3)%4+4*c]);
        for (int i = 0; i < 16; i++) enc_round[127-8*i -: 8] = o[i];
    endfunction

    function automatic logic [127:0] dec_sub(input logic [127:0] s);
        logic [7:0] t [16];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r + 4*((c+r)%4)] = s[127-8*(r+4*c) -: 8];
        for (int i = 0; i < 16; i++) dec_sub[127-8*i -: 8] = ISBOX[t[i]];
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0] t [16];
        for (int i = 0; i < 16; i++) t[i] = s[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                inv_mix[127-8*(r+4*c) -: 8] =
                    gmul(t[r+4*c], 8'h0e) ^ gmul(t[(r+1)%4+4*c], 8'h0b)
                    ^ gmul(t[(r+2)%4+4*c], 8'h0d) ^ gmul(t[(r+3)%4+4*c], 8'h09);
    endfunction

endpackage

@@ hw/rtl/aes256_ecb_block_cipher_core.sv @@
// the first block after reset or a key write waits while the schedule is expanded, one
// memory entry per cycle; a new block is taken only in idle, after the previous result is taken
// each of the 15 key additions reads its 128-bit round key as two halves from the
// registered-read round key memory
// reset: rst_n asynchronous, clears control and key registers; round key memory is not cleared
module aes256_ecb_block_cipher_core
    import aes_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // block_low, block_high
    input  logic         s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // result_low, result_high
);

    localparam int DEPTH  = 2 * (ROUND_COUNT + 1);
    localparam int AW     = $clog2(DEPTH);
    localparam int RW     = $clog2(ROUND_COUNT + 1);
    localparam int SW     = $clog2(ROUND_COUNT + 2);

    logic [63:0] key_reg [NUM_KEY_REGS];
    logic        ready_sched_reg;
    state_t      state_reg;

    // round key memory, one 64-bit half per entry
    logic [63:0]   rk_mem [DEPTH];
    logic [63:0]   rd_data;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en) rk_mem[wr_addr] <= wr_data;
        rd_data <= rk_mem[rd_addr];
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = key_reg[paddr[4:3]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEY_REGS; i++) key_reg[i] <= 64'h0;
        end
        else if (cfg_wr)
        begin
            key_reg[paddr[4:3]] <= pwdata;
        end
    end

    // expansion: eight-word window, one entry of two words per cycle
    logic [31:0]   win_reg [8];
    logic [AW-1:0] ecnt_reg;
    logic [7:0]    rcon_reg;
    logic [31:0]   n0, n1, t0;

    // the new word index is 2*ecnt+8, so its place in the eight-word cycle follows ecnt
    always_comb
    begin
        if (ecnt_reg[1:0] == 2'd0)
            t0 = sub_word({win_reg[7][23:0], win_reg[7][31:24]}) ^ {rcon_reg, 24'h0};
        else if (ecnt_reg[1:0] == 2'd2)
            t0 = sub_word(win_reg[7]);
        else
            t0 = win_reg[7];
        n0 = win_reg[0] ^ t0;
        n1 = win_reg[1] ^ n0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ready_sched_reg <= 1'b0;
        else if (cfg_wr)
            ready_sched_reg <= 1'b0;
        else if (state_reg == ST_EXP && ecnt_reg == AW'(DEPTH - 1))
            ready_sched_reg <= 1'b1;
    end

    logic          dec_reg;
    logic [SW-1:0] step_reg;
    logic          phase_reg;
    logic [127:0]  st_reg;
    logic [63:0]   khi_reg;
    logic [127:0]  rk;
    logic [RW-1:0] rk_round;
    logic [SW-1:0] app_step;
    logic [127:0]  dsub;
    logic [127:0]  st_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {st_reg[63:0], st_reg[127:64]};
    assign rk       = {khi_reg, rd_data};

    assign wr_en    = (state_reg == ST_EXP);
    assign wr_addr  = ecnt_reg;
    assign wr_data  = {win_reg[0], win_reg[1]};

    // phase 0 reads the high half of a round key, phase 1 the low half
    assign rk_round = dec_reg ? RW'(ROUND_COUNT - int'(step_reg)) : RW'(step_reg);
    assign rd_addr  = AW'({rk_round, phase_reg});

    // the key of the previous step is complete when phase 0 comes round again
    always_comb
    begin
        app_step = step_reg - SW'(1);
        dsub     = dec_sub(st_reg) ^ rk;
        if (app_step == '0)
            st_next = st_reg ^ rk;
        else if (!dec_reg)
            st_next = enc_round(st_reg, app_step == SW'(ROUND_COUNT)) ^ rk;
        else if (app_step == SW'(ROUND_COUNT))
            st_next = dsub;
        else
            st_next = inv_mix(dsub);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dec_reg   <= 1'b0;
            step_reg  <= '0;
            phase_reg <= 1'b0;
            st_reg    <= '0;
            khi_reg   <= '0;
            ecnt_reg  <= '0;
            rcon_reg  <= 8'h01;
            for (int i = 0; i < 8; i++) win_reg[i] <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        dec_reg   <= (s_tuser == CMD_DEC);
                        st_reg    <= {s_tdata[63:0], s_tdata[127:64]};
                        step_reg  <= '0;
                        phase_reg <= 1'b0;
                        if (!ready_sched_reg)
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                win_reg[2*i]   <= key_reg[i][63:32];
                                win_reg[2*i+1] <= key_reg[i][31:0];
                            end
                            ecnt_reg  <= '0;
                            rcon_reg  <= 8'h01;
                            state_reg <= ST_EXP;
                        end
                        else
                            state_reg <= ST_RUN;
                    end
                end
                ST_EXP:
                begin
                    for (int i = 0; i < 6; i++) win_reg[i] <= win_reg[i+2];
                    win_reg[6] <= n0;
                    win_reg[7] <= n1;
                    if (ecnt_reg[1:0] == 2'd0) rcon_reg <= xtime(rcon_reg);
                    ecnt_reg <= ecnt_reg + AW'(1);
                    if (ecnt_reg == AW'(DEPTH - 1)) state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (!phase_reg)
                    begin
                        if (step_reg != '0) st_reg <= st_next;
                        if (step_reg == SW'(ROUND_COUNT + 1))
                            state_reg <= ST_OUT;
                        else
                            phase_reg <= 1'b1;
                    end
                    else
                    begin
                        khi_reg   <= rd_data;
                        step_reg  <= step_reg + SW'(1);
                        phase_reg <= 1'b0;
                    end
                end
                ST_OUT:
                begin
                    if (m_tready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg));
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));
    a_run_sched: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> ready_sched_reg);
    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN && step_reg <= SW'(ROUND_COUNT) |-> rd_addr < AW'(DEPTH));

endmodule

@@ tb/tb_top.sv @@
module tb_top
    import aes_pkg::*;
();

    localparam int KEY_IDX_0   = 0;
    localparam int KEY_IDX_3   = 3;
    localparam int IDLE_WAIT   = 60;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 287;
    localparam int FIPS_ROW    = 10;

    typedef struct packed {
        logic        cmd;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        known;
        logic [63:0] exp_hi;
        logic [63:0] exp_lo;
    } dir_row_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } block_t;

    localparam dir_row_t DIR_ROWS [14] = '{
        // zero key after reset
        '{1'b0, 64'h0, 64'h0, 1'b1, 64'hdc95c078a2408989, 64'had48a21492842087},
        '{1'b1, 64'hdc95c078a2408989, 64'had48a21492842087, 1'b1, 64'h0, 64'h0},
        '{1'b0, '1, '1, 1'b0, 64'h0, 64'h0},
        '{1'b1, '1, '1, 1'b0, 64'h0, 64'h0},
        '{1'b1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 64'h0, 64'h0},
        '{1'b1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h8000000000000000, 64'h0000000000000001, 1'b0, 64'h0, 64'h0},
        '{1'b1, 64'h0000000000000001, 64'h8000000000000000, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 64'h0, 64'h0},
        // standard test key 00..1f
        '{1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
          64'h8ea2b7ca516745bf, 64'heafc49904b496089},
        '{1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1,
          64'h0011223344556677, 64'h8899aabbccddeeff},
        '{1'b0, '1, 64'h0, 1'b0, 64'h0, 64'h0},
        '{1'b1, 64'h0, '1, 1'b0, 64'h0, 64'h0}
    };

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;

    logic [7:0]   sbox_tab [256];
    logic [7:0]   isbox_tab [256];
    logic [127:0] round_key [15];
    logic [63:0]  key_reg [4];
    block_t       expected_blocks [$];
    int           fail_count;
    int           requests_sent;
    int           stall_cycles;
    bit           hold_done;

    aes256_ecb_block_cipher_core u_top (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = xt(a);
        end
        return p;
    endfunction

    function automatic void build_sboxes();
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++)
        begin
            // x^254 is the field inverse, zero maps to zero
            inv = 8'h01;
            for (int e = 0; e < 254; e++)
                inv = fmul(inv, x[7:0]);
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sbox_tab[x] = s;
            isbox_tab[s] = x[7:0];
        end
    endfunction

    function automatic logic [31:0] sub_w(input logic [31:0] w);
        return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
    endfunction

    function automatic void expand_keys();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        for (int i = 0; i < 8; i++)
            w[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
        for (int i = 8; i < 60; i++)
        begin
            t = w[i-1];
            if (i % 8 == 0)
            begin
                t = sub_w({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = xt(rcon);
            end
            else if (i % 8 == 4)
                t = sub_w(t);
            w[i] = w[i-8] ^ t;
        end
        for (int r = 0; r < 15; r++)
            round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function automatic block_t cipher_block(input logic cmd, input logic [63:0] hi,
                                            input logic [63:0] lo);
        logic [127:0] full;
        logic [7:0]   st [16];
        logic [7:0]   t [16];
        logic [7:0]   mx [4];
        logic [7:0]   acc;
        int           rnd;
        block_t       res;
        full = {hi, lo};
        for (int i = 0; i < 16; i++)
            st[i] = full[127-8*i -: 8];
        for (int step = 0; step <= 14; step++)
        begin
            rnd = (cmd == CMD_DEC) ? 14 - step : step;
            if (step > 0 && cmd == CMD_ENC)
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[r+4*c] = sbox_tab[st[r+4*((c+r)%4)]];
                st = t;
                if (step < 14)
                begin
                    mx = '{8'd2, 8'd3, 8'd1, 8'd1};
                    for (int c = 0; c < 4; c++)
                        for (int r = 0; r < 4; r++)
                        begin
                            acc = 8'h00;
                            for (int j = 0; j < 4; j++)
                                acc ^= fmul(mx[(j-r+4)%4], st[j+4*c]);
                            t[r+4*c] = acc;
                        end
                    st = t;
                end
            end
            else if (step > 0)
            begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[r+4*((c+r)%4)] = isbox_tab[st[r+4*c]];
                st = t;
            end
            for (int i = 0; i < 16; i++)
                st[i] ^= round_key[rnd][127-8*i -: 8];
            // inverse mix follows the key add in every middle decrypt round
            if (cmd == CMD_DEC && step > 0 && step < 14)
            begin
                mx = '{8'd14, 8'd11, 8'd13, 8'd9};
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                    begin
                        acc = 8'h00;
                        for (int j = 0; j < 4; j++)
                            acc ^= fmul(mx[(j-r+4)%4], st[j+4*c]);
                        t[r+4*c] = acc;
                    end
                st = t;
            end
        end
        for (int i = 0; i < 16; i++)
            full[127-8*i -: 8] = st[i];
        res.hi = full[127:64];
        res.lo = full[63:0];
        return res;
    endfunction

    task automatic wait_idle();
        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_key(input int idx, input logic [63:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 5'(idx * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
        begin
            $error("key_word_%0d readback: expected %h actual %h", idx, value, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        key_reg[idx] = value;
        expand_keys();
        @(posedge clk);
    endtask

    task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        wait_idle();
        write_key(KEY_IDX_0, k0);
        write_key(KEY_IDX_0 + 1, k1);
        write_key(KEY_IDX_0 + 2, k2);
        write_key(KEY_IDX_3, k3);
    endtask

    // one request; valid is then held low for an idle gap when gap is positive
    task automatic send_block(input logic cmd, input logic [63:0] hi, input logic [63:0] lo,
                              input bit known, input block_t typed, input int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {lo, hi};
        do
            @(posedge clk);
        while (!s_tready);
        expected_blocks.push_back(known ? typed : cipher_block(cmd, hi, lo));
        requests_sent++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // receiver: random stalls, quiet stretches, and one long hold-off
    initial
    begin
        int pat;
        m_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!hold_done && requests_sent >= 300)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                pat = $urandom_range(0, 99);
                if (pat < 40)
                    m_tready <= 1'b1;
                else if (pat < 70)
                    m_tready <= 1'($urandom_range(0, 1));
                else
                    m_tready <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_blocks.size() == 0)
            begin
                $error("result with nothing expected: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                block_t e;
                e = expected_blocks.pop_front();
                if (m_tdata[63:0] !== e.hi)
                begin
                    $error("result_high: expected %h actual %h", e.hi, m_tdata[63:0]);
                    fail_count++;
                end
                if (m_tdata[127:64] !== e.lo)
                begin
                    $error("result_low: expected %h actual %h", e.lo, m_tdata[127:64]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either stream and no register access
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        block_t typed;
        int     burst;
        int     gap;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        fail_count    = 0;
        requests_sent = 0;
        key_reg       = '{default: '0};
        build_sboxes();
        expand_keys();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIR_ROWS); i++)
        begin
            if (i == FIPS_ROW)
            begin
                s_tvalid <= 1'b0;
                load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                         64'h1011121314151617, 64'h18191a1b1c1d1e1f);
            end
            typed.hi = DIR_ROWS[i].exp_hi;
            typed.lo = DIR_ROWS[i].exp_lo;
            send_block(DIR_ROWS[i].cmd, DIR_ROWS[i].hi, DIR_ROWS[i].lo,
                       DIR_ROWS[i].known, typed, $urandom_range(0, 3));
        end
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: load_key(64'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                            64'($urandom));
                1: load_key('1, '1, '1, '1);
                2: load_key('0, '0, '0, '0);
                default: load_key(rand_word(), rand_word(), rand_word(), rand_word());
            endcase
            burst = 0;
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                gap = 0;
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
                burst--;
                send_block(1'($urandom_range(0, 1)), rand_word(), rand_word(), 1'b0, '0,
                           (n == RAND_ITEMS - 1) ? 0 : gap);
            end
            s_tvalid <= 1'b0;
        end

        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ aes256_ecb_block_cipher_core.f @@
hw/rtl/aes_pkg.sv
hw/rtl/aes256_ecb_block_cipher_core.sv
tb/tb_top.sv
